// ===== sv/lces_pkg.sv =====
// Shared constants, types and codes for the load-cell EMA stability core.
`timescale 1ns / 1ps
package lces_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);
  localparam int MIN_SAMPLES  = 5;

  localparam int RAW_W    = 24;
  localparam int WEIGHT_W = 32;
  localparam int DIFF_W   = RAW_W + 1;
  localparam int DQ_W     = DIFF_W + 32;
  localparam int DIV_STEPS = DQ_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int ALPHA_W = 17;
  localparam int THR_W   = 31;

  localparam logic [ALPHA_W-1:0]         Q_ONE       = 17'd65536;
  localparam logic signed [WEIGHT_W-1:0] FACTOR_ONE  = 32'sd65536;
  localparam logic signed [WEIGHT_W-1:0] TINY_FACTOR = 32'sd66;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_TARE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd3;

  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 72;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SAT,
    ST_MUL,
    ST_ADD,
    ST_WRITE,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic sat;
    logic ema_mul;
    logic ema_add;
    logic hist_write;
    logic scan_init;
    logic scan_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic short_hist;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/lces_ctrl.sv =====
// Sequencer for one transaction: divide, filter, record, window scan, result; a clear skips to the scan.
`timescale 1ns / 1ps
module lces_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lces_pkg::dp_status_t  sts_i,
  output lces_pkg::ctrl_cmd_t   cmd_o
);

  lces_pkg::state_e state_q, state_d;
  logic [lces_pkg::DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic div_last;

  assign div_last = (div_cnt_q == lces_pkg::DIV_CNT_W'(lces_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lces_pkg::ST_IDLE;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    case (state_q)
      lces_pkg::ST_IDLE: begin
        div_cnt_d = '0;
        if (in_valid_i) begin
          state_d = lces_pkg::ST_DIV;
        end
      end
      lces_pkg::ST_DIV: begin
        if (sts_i.op_clear) begin
          state_d = lces_pkg::ST_SCAN_INIT;
        end else if (div_last) begin
          state_d = lces_pkg::ST_SAT;
        end else begin
          div_cnt_d = div_cnt_q + 1'b1;
        end
      end
      lces_pkg::ST_SAT:   state_d = lces_pkg::ST_MUL;
      lces_pkg::ST_MUL:   state_d = lces_pkg::ST_ADD;
      lces_pkg::ST_ADD:   state_d = lces_pkg::ST_WRITE;
      lces_pkg::ST_WRITE: state_d = lces_pkg::ST_SCAN_INIT;
      lces_pkg::ST_SCAN_INIT: begin
        state_d = sts_i.short_hist ? lces_pkg::ST_OUT : lces_pkg::ST_SCAN;
      end
      lces_pkg::ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = lces_pkg::ST_OUT;
        end
      end
      lces_pkg::ST_OUT: begin
        if (sts_i.out_free) begin
          state_d = lces_pkg::ST_IDLE;
        end
      end
      default: state_d = lces_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      lces_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      lces_pkg::ST_DIV:       cmd_o.div_step   = !sts_i.op_clear;
      lces_pkg::ST_SAT:       cmd_o.sat        = 1'b1;
      lces_pkg::ST_MUL:       cmd_o.ema_mul    = 1'b1;
      lces_pkg::ST_ADD:       cmd_o.ema_add    = 1'b1;
      lces_pkg::ST_WRITE:     cmd_o.hist_write = 1'b1;
      lces_pkg::ST_SCAN_INIT: cmd_o.scan_init  = 1'b1;
      lces_pkg::ST_SCAN:      cmd_o.scan_step  = 1'b1;
      lces_pkg::ST_OUT:       cmd_o.out_load   = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== sv/lces_dp.sv =====
// Datapath: settings, serial divider, EMA, history ring, window scan, result register.
`timescale 1ns / 1ps
module lces_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lces_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lces_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_op_i,
  input  logic [lces_pkg::RAW_W-1:0]           in_raw_i,
  input  lces_pkg::ctrl_cmd_t                  cmd_i,
  output lces_pkg::dp_status_t                 sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [lces_pkg::M_TDATA_W-1:0]       out_data_o
);

  localparam int W  = lces_pkg::WEIGHT_W;
  localparam int DW = lces_pkg::DIFF_W;
  localparam int QW = lces_pkg::DQ_W;
  localparam int PW = lces_pkg::ALPHA_W + 1 + W + 1;
  localparam int SW = PW + 1;

  logic signed [lces_pkg::RAW_W-1:0] tare_q;
  logic signed [W-1:0]               scale_q;
  logic [lces_pkg::ALPHA_W-1:0]      alpha_q;
  logic [lces_pkg::THR_W-1:0]        thr_q;

  logic              op_q;
  logic              q_neg_q;
  logic [W-1:0]      div_q;
  logic [W-1:0]      rem_q;
  logic [QW-1:0]     dq_q;
  logic signed [W-1:0] weight_q;
  logic signed [W-1:0] smooth_q;
  logic signed [PW-1:0] prod_q;
  logic [W-1:0]      hist_q [lces_pkg::WINDOW_DEPTH];
  logic [lces_pkg::SLOT_W-1:0] slot_q;
  logic              filled_q;
  logic [lces_pkg::SLOT_W-1:0] idx_q;
  logic signed [W-1:0] lo_q, hi_q;
  logic              out_valid_q;
  logic [lces_pkg::M_TDATA_W-1:0] out_data_q;

  // load-time operands
  logic signed [DW-1:0] diff;
  logic                 diff_neg;
  logic [DW-1:0]        diff_mag;
  logic signed [W-1:0]  factor_eff;
  logic                 f_neg;

  always_comb begin
    diff       = DW'($signed(in_raw_i)) - DW'(tare_q);
    diff_neg   = diff[DW-1];
    diff_mag   = diff_neg ? DW'(-diff) : DW'(diff);
    factor_eff = (scale_q > -lces_pkg::TINY_FACTOR && scale_q < lces_pkg::TINY_FACTOR)
                 ? lces_pkg::FACTOR_ONE : scale_q;
    f_neg      = factor_eff[W-1];
  end

  // one restoring division step
  logic [W:0] shifted;
  logic       ge;
  logic [W:0] sub;

  always_comb begin
    shifted = {rem_q, dq_q[QW-1]};
    ge      = (shifted >= {1'b0, div_q});
    sub     = shifted - {1'b0, div_q};
  end

  // saturate the quotient magnitude
  logic         pos_ovf, neg_ovf;
  logic [W-1:0] sat_val;

  always_comb begin
    pos_ovf = |dq_q[QW-1:W-1];
    neg_ovf = (|dq_q[QW-1:W]) || (dq_q[W-1] && (|dq_q[W-2:0]));
    if (q_neg_q) begin
      sat_val = neg_ovf ? {1'b1, {(W-1){1'b0}}} : W'(-dq_q[W-1:0]);
    end else begin
      sat_val = pos_ovf ? {1'b0, {(W-1){1'b1}}} : dq_q[W-1:0];
    end
  end

  // EMA: prev*2^16 + alpha*(w - prev) + half, floored by 2^16
  logic [lces_pkg::ALPHA_W-1:0] alpha_eff;
  logic signed [W:0]            delta;
  logic signed [SW-1:0]         ema_sum;

  always_comb begin
    alpha_eff = (alpha_q > lces_pkg::Q_ONE) ? lces_pkg::Q_ONE : alpha_q;
    delta     = (W+1)'(weight_q) - (W+1)'(smooth_q);
    ema_sum   = (SW'(smooth_q) <<< 16) + SW'(prod_q) + SW'(32768);
  end

  // window status
  logic [lces_pkg::COUNT_W-1:0] count;
  logic signed [W-1:0]          cur;
  logic signed [W:0]            spread;
  logic                         stable;

  always_comb begin
    count  = filled_q ? lces_pkg::COUNT_W'(lces_pkg::WINDOW_DEPTH)
                      : lces_pkg::COUNT_W'(slot_q);
    cur    = hist_q[idx_q];
    spread = (W+1)'(hi_q) - (W+1)'(lo_q);
    stable = (count >= lces_pkg::COUNT_W'(lces_pkg::MIN_SAMPLES))
             && (spread <= $signed({2'b00, thr_q}));
  end

  assign sts_o.op_clear   = (op_q == lces_pkg::OP_CLEAR);
  assign sts_o.short_hist = (count < lces_pkg::COUNT_W'(lces_pkg::MIN_SAMPLES));
  assign sts_o.scan_last  = (lces_pkg::COUNT_W'(idx_q) == count - 1'b1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tare_q   <= '0;
      scale_q  <= lces_pkg::FACTOR_ONE;
      alpha_q  <= 17'd19661;
      thr_q    <= 31'd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lces_pkg::CFG_TARE:   tare_q  <= cfg_data_i[lces_pkg::RAW_W-1:0];
        lces_pkg::CFG_SCALE:  scale_q <= cfg_data_i;
        lces_pkg::CFG_ALPHA:  alpha_q <= cfg_data_i[lces_pkg::ALPHA_W-1:0];
        lces_pkg::CFG_THRESH: thr_q   <= cfg_data_i[lces_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q    <= '0;
      weight_q    <= '0;
      slot_q      <= '0;
      filled_q    <= 1'b0;
      out_valid_q <= 1'b0;
      op_q        <= lces_pkg::OP_PROCESS;
    end else begin
      if (cmd_i.load) begin
        op_q <= in_op_i;
        if (in_op_i == lces_pkg::OP_CLEAR) begin
          smooth_q <= '0;
        end
      end
      if (cmd_i.sat) begin
        weight_q <= sat_val;
      end
      if (cmd_i.ema_add) begin
        smooth_q <= ema_sum[W+15:16];
      end
      if (cmd_i.hist_write) begin
        if (slot_q == lces_pkg::SLOT_W'(lces_pkg::WINDOW_DEPTH - 1)) begin
          slot_q   <= '0;
          filled_q <= 1'b1;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dq_q    <= {diff_mag, {W{1'b0}}};
      rem_q   <= '0;
      div_q   <= f_neg ? W'(-factor_eff) : W'(factor_eff);
      q_neg_q <= diff_neg ^ f_neg;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? sub[W-1:0] : shifted[W-1:0];
      dq_q  <= {dq_q[QW-2:0], ge};
    end
    if (cmd_i.ema_mul) begin
      prod_q <= PW'($signed({1'b0, alpha_eff})) * PW'(delta);
    end
    if (cmd_i.hist_write) begin
      hist_q[slot_q] <= smooth_q;
    end
    if (cmd_i.scan_init) begin
      idx_q <= '0;
      lo_q  <= {1'b0, {(W-1){1'b1}}};
      hi_q  <= {1'b1, {(W-1){1'b0}}};
    end
    if (cmd_i.scan_step) begin
      idx_q <= idx_q + 1'b1;
      if (cur < lo_q) lo_q <= cur;
      if (cur > hi_q) hi_q <= cur;
    end
    if (cmd_i.out_load) begin
      out_data_q <= {{(lces_pkg::M_TDATA_W-2*W-1){1'b0}}, stable, smooth_q, weight_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/load_cell_ema_stability_core.sv =====
// Sequence: an input transaction runs the 57 divider steps, then saturation, EMA multiply and add,
// history write and scan set-up, a scan over each history entry once five are held, and the
// result register; a clear skips the divider, EMA and history write and goes to the scan set-up.
// Throughput: one item at a time, next input taken the cycle after the result is registered.
// Reset: asynchronous, active low; clears filter and history pointer, restores settings.
// Top level of the load-cell EMA stability core.
`timescale 1ns / 1ps
module load_cell_ema_stability_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lces_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lces_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lces_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [23:0] raw_sample
  input  logic                                s_axis_tuser,  // [0] operation
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lces_pkg::M_TDATA_W-1:0]      m_axis_tdata   // [31:0] weight_now,
                                                             // [63:32] weight_smoothed,
                                                             // [64] is_stable, [71:65] zero
);

  lces_pkg::ctrl_cmd_t  cmd;
  lces_pkg::dp_status_t sts;

  lces_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lces_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_op_i     (s_axis_tuser),
    .in_raw_i    (s_axis_tdata[lces_pkg::RAW_W-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a transaction is in flight");

  a_one_command : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.div_step, cmd.sat, cmd.ema_mul, cmd.ema_add,
              cmd.hist_write, cmd.scan_init, cmd.scan_step, cmd.out_load}))
    else $error("conflicting datapath commands");

  a_result_registered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> m_axis_tvalid)
    else $error("result load did not raise output valid");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the load-cell EMA stability core: a directed table, then randomised phases.
`timescale 1ns / 1ps
module tb_top;

  localparam int     IDLE_LIMIT  = 3000;
  localparam int     PHASES      = 15;
  localparam int     PHASE_ITEMS = 76;
  localparam longint WEIGHT_MAX  = 64'sd2147483647;
  localparam longint WEIGHT_MIN  = -64'sd2147483648;

  typedef struct packed {
    logic signed [lces_pkg::WEIGHT_W-1:0] weight_now;
    logic signed [lces_pkg::WEIGHT_W-1:0] weight_smoothed;
    logic                                 is_stable;
  } reading_t;

  typedef struct packed {
    logic                            is_write;
    logic [lces_pkg::CFG_IDX_W-1:0]  idx;
    logic [lces_pkg::CFG_DATA_W-1:0] data;
    logic                            op;
    logic                            typed;
    reading_t                        want;
  } stim_row_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [lces_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [lces_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [lces_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                            s_axis_tuser  = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [lces_pkg::M_TDATA_W-1:0]  m_axis_tdata;

  load_cell_ema_stability_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // [23:0] raw_sample
    .s_axis_tuser  (s_axis_tuser),  // [0] operation
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)   // [31:0] weight_now, [63:32] weight_smoothed,
                                    // [64] is_stable, [71:65] zero
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Scale model: settings and filter state
  logic signed [lces_pkg::RAW_W-1:0]    tare_q;
  logic signed [lces_pkg::WEIGHT_W-1:0] scale_q;
  logic [lces_pkg::ALPHA_W-1:0]         alpha_q;
  logic [lces_pkg::THR_W-1:0]           thr_q;
  logic signed [lces_pkg::WEIGHT_W-1:0] smooth_q;
  logic signed [lces_pkg::WEIGHT_W-1:0] last_weight_q;
  logic signed [lces_pkg::WEIGHT_W-1:0] hist_q [lces_pkg::WINDOW_DEPTH];
  int                                   slot_q;
  bit                                   filled_q;

  reading_t  pending_readings [$];
  stim_row_t stim_rows [$];
  reading_t  head_reading;
  int        mismatches  = 0;
  int        idle_cycles = 0;
  bit        burst_q     = 1'b0;
  bit        dirty_q     = 1'b0;

  function automatic logic signed [lces_pkg::WEIGHT_W-1:0] weigh_sample(
      logic signed [lces_pkg::RAW_W-1:0] raw);
    longint diff;
    longint divisor;
    longint quo;
    diff    = longint'(raw) - longint'(tare_q);
    divisor = longint'(scale_q);
    if (divisor > -longint'(lces_pkg::TINY_FACTOR) &&
        divisor < longint'(lces_pkg::TINY_FACTOR)) begin
      divisor = longint'(lces_pkg::FACTOR_ONE);
    end
    quo = (diff * 64'sd4294967296) / divisor;
    if (quo > WEIGHT_MAX) begin
      quo = WEIGHT_MAX;
    end
    if (quo < WEIGHT_MIN) begin
      quo = WEIGHT_MIN;
    end
    return quo[lces_pkg::WEIGHT_W-1:0];
  endfunction

  function automatic logic signed [lces_pkg::WEIGHT_W-1:0] smooth(
      logic signed [lces_pkg::WEIGHT_W-1:0] w, logic signed [lces_pkg::WEIGHT_W-1:0] prev);
    longint a;
    longint acc;
    if (alpha_q > lces_pkg::Q_ONE) begin
      a = longint'(lces_pkg::Q_ONE);
    end else begin
      a = longint'(alpha_q);
    end
    acc = a * longint'(w) + (longint'(lces_pkg::Q_ONE) - a) * longint'(prev) + 64'sd32768;
    acc = acc >>> 16;
    return acc[lces_pkg::WEIGHT_W-1:0];
  endfunction

  function automatic logic window_is_steady();
    int                                   count;
    int                                   i;
    logic signed [lces_pkg::WEIGHT_W-1:0] lo;
    logic signed [lces_pkg::WEIGHT_W-1:0] hi;
    count = filled_q ? lces_pkg::WINDOW_DEPTH : slot_q;
    if (count < lces_pkg::MIN_SAMPLES) begin
      return 1'b0;
    end
    lo = hist_q[0];
    hi = hist_q[0];
    for (i = 1; i < count; i++) begin
      if (hist_q[i] < lo) begin
        lo = hist_q[i];
      end
      if (hist_q[i] > hi) begin
        hi = hist_q[i];
      end
    end
    return (longint'(hi) - longint'(lo)) <= longint'(thr_q);
  endfunction

  function automatic reading_t advance_scale(logic op, logic signed [lces_pkg::RAW_W-1:0] raw);
    reading_t r;
    if (op == lces_pkg::OP_CLEAR) begin
      smooth_q = '0;
    end else begin
      last_weight_q  = weigh_sample(raw);
      smooth_q       = smooth(last_weight_q, smooth_q);
      hist_q[slot_q] = smooth_q;
      slot_q++;
      if (slot_q >= lces_pkg::WINDOW_DEPTH) begin
        slot_q   = 0;
        filled_q = 1'b1;
      end
    end
    r.weight_now      = last_weight_q;
    r.weight_smoothed = smooth_q;
    r.is_stable       = window_is_steady();
    return r;
  endfunction

  function automatic void apply_setting(logic [lces_pkg::CFG_IDX_W-1:0] idx,
                                        logic [lces_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      lces_pkg::CFG_TARE:   tare_q  = data[lces_pkg::RAW_W-1:0];
      lces_pkg::CFG_SCALE:  scale_q = data;
      lces_pkg::CFG_ALPHA:  alpha_q = data[lces_pkg::ALPHA_W-1:0];
      lces_pkg::CFG_THRESH: thr_q   = data[lces_pkg::THR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_write(logic [lces_pkg::CFG_IDX_W-1:0] idx,
                                    logic [lces_pkg::CFG_DATA_W-1:0] data);
    stim_row_t row;
    row          = '0;
    row.is_write = 1'b1;
    row.idx      = idx;
    row.data     = data;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_item(logic op, logic [lces_pkg::RAW_W-1:0] raw);
    stim_row_t row;
    row      = '0;
    row.op   = op;
    row.data = {{(lces_pkg::CFG_DATA_W-lces_pkg::RAW_W){1'b0}}, raw};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_check(logic op, logic [lces_pkg::RAW_W-1:0] raw,
                                    logic [lces_pkg::WEIGHT_W-1:0] w,
                                    logic [lces_pkg::WEIGHT_W-1:0] s, logic st);
    stim_row_t row;
    row                      = '0;
    row.op                   = op;
    row.data                 = {{(lces_pkg::CFG_DATA_W-lces_pkg::RAW_W){1'b0}}, raw};
    row.typed                = 1'b1;
    row.want.weight_now      = w;
    row.want.weight_smoothed = s;
    row.want.is_stable       = st;
    stim_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string field, logic [lces_pkg::WEIGHT_W-1:0] got,
                                 logic [lces_pkg::WEIGHT_W-1:0] want);
    $display("mismatch %s: got %h, expected %h", field, got, want);
    mismatches++;
  endtask

  task automatic write_reg(logic [lces_pkg::CFG_IDX_W-1:0] idx,
                           logic [lces_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    apply_setting(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid and hold until every expected reading is back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    dirty_q = 1'b0;
  endtask

  task automatic send_item(logic op, logic [lces_pkg::RAW_W-1:0] raw, logic typed,
                           reading_t want);
    int       gap;
    reading_t predicted;
    gap = burst_q ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_scale(op, raw);
    pending_readings.push_back(typed ? want : predicted);
    dirty_q = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
      end else begin
        head_reading = pending_readings.pop_front();
        if (m_axis_tdata[31:0] !== head_reading.weight_now) begin
          report_mismatch("weight_now", m_axis_tdata[31:0], head_reading.weight_now);
        end
        if (m_axis_tdata[63:32] !== head_reading.weight_smoothed) begin
          report_mismatch("weight_smoothed", m_axis_tdata[63:32], head_reading.weight_smoothed);
        end
        if (m_axis_tdata[64] !== head_reading.is_stable) begin
          report_mismatch("is_stable", {31'b0, m_axis_tdata[64]},
                          {31'b0, head_reading.is_stable});
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int open_len;
    int stall_len;
    while (!rst_ni) begin
      @(posedge clk_i);
    end
    forever begin
      open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 500) : $urandom_range(1, 24);
      m_axis_tready <= 1'b1;
      repeat (open_len) @(posedge clk_i);
      stall_len = pick_gap() + 1;
      m_axis_tready <= 1'b0;
      repeat (stall_len) @(posedge clk_i);
    end
  end

  initial begin
    int                              phase;
    int                              k;
    int                              mode;
    int                              noise;
    int                              sv;
    logic [lces_pkg::CFG_DATA_W-1:0] val;
    logic [lces_pkg::RAW_W-1:0]      base;
    logic [lces_pkg::RAW_W-1:0]      raw;
    logic                            op;

    tare_q        = '0;
    scale_q       = lces_pkg::FACTOR_ONE;
    alpha_q       = 17'd19661;
    thr_q         = 31'd65536;
    smooth_q      = '0;
    last_weight_q = '0;
    slot_q        = 0;
    filled_q      = 1'b0;
    for (k = 0; k < lces_pkg::WINDOW_DEPTH; k++) begin
      hist_q[k] = '0;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_check(lces_pkg::OP_CLEAR,   24'h000000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    add_check(lces_pkg::OP_PROCESS, 24'h000000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    add_write(lces_pkg::CFG_ALPHA, 32'h0001_0000);
    add_check(lces_pkg::OP_PROCESS, 24'h7FFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_check(lces_pkg::OP_PROCESS, 24'h800000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    add_check(lces_pkg::OP_CLEAR,   24'h5A5A5A, 32'h8000_0000, 32'h0000_0000, 1'b0);
    add_write(lces_pkg::CFG_SCALE, 32'd65);
    add_check(lces_pkg::OP_PROCESS, 24'h000001, 32'h0001_0000, 32'h0001_0000, 1'b0);
    add_write(lces_pkg::CFG_SCALE, 32'hFFFF_FFBF);
    add_check(lces_pkg::OP_PROCESS, 24'h000001, 32'h0001_0000, 32'h0001_0000, 1'b0);
    add_write(lces_pkg::CFG_SCALE, 32'd66);
    add_item(lces_pkg::OP_PROCESS, 24'd100);
    add_write(lces_pkg::CFG_SCALE, 32'hFFFF_FFBE);
    add_item(lces_pkg::OP_PROCESS, 24'hFFFF9C);
    add_write(lces_pkg::CFG_SCALE, 32'h7FFF_FFFF);
    add_item(lces_pkg::OP_PROCESS, 24'h7FFFFF);
    add_write(lces_pkg::CFG_SCALE, 32'h8000_0000);
    add_item(lces_pkg::OP_PROCESS, 24'h7FFFFF);
    add_write(lces_pkg::CFG_SCALE, lces_pkg::FACTOR_ONE);
    add_write(lces_pkg::CFG_TARE, 32'hA57F_FFFF);
    add_item(lces_pkg::OP_PROCESS, 24'h800000);
    add_write(lces_pkg::CFG_TARE, 32'h5A80_0000);
    add_item(lces_pkg::OP_PROCESS, 24'h7FFFFF);
    add_write(lces_pkg::CFG_TARE, 32'h0000_0000);
    add_write(lces_pkg::CFG_ALPHA, 32'h0000_0000);
    add_item(lces_pkg::OP_PROCESS, 24'h001388);
    add_write(lces_pkg::CFG_ALPHA, 32'h0001_FFFF);
    add_item(lces_pkg::OP_PROCESS, 24'h00007B);
    add_item(lces_pkg::OP_PROCESS, 24'hFFFFFF);
    add_write(lces_pkg::CFG_ALPHA, 32'hFFFE_4CCD);
    add_write(lces_pkg::CFG_THRESH, 32'h0000_0000);
    add_item(lces_pkg::OP_PROCESS, 24'h000007);
    add_item(lces_pkg::OP_CLEAR,   24'hFFFFFF);
    add_write(lces_pkg::CFG_THRESH, 32'hFFFF_FFFF);
    add_item(lces_pkg::OP_PROCESS, 24'h000007);
    add_item(lces_pkg::OP_PROCESS, 24'h000007);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_write) begin
        if (dirty_q) begin
          wait_idle();
        end
        write_reg(stim_rows[i].idx, stim_rows[i].data);
      end else begin
        send_item(stim_rows[i].op, stim_rows[i].data[lces_pkg::RAW_W-1:0], stim_rows[i].typed,
                  stim_rows[i].want);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();

      case ($urandom_range(0, 4))
        0: val = '0;
        1: val = $urandom;
        2: val = ($urandom & 32'hFF00_0000) | 32'h007F_FFFF;
        3: val = ($urandom & 32'hFF00_0000) | 32'h0080_0000;
        default: begin
          sv  = $urandom_range(0, 2000) - 1000;
          val = sv;
        end
      endcase
      write_reg(lces_pkg::CFG_TARE, val);

      case ($urandom_range(0, 6))
        1: begin
          sv  = $urandom_range(0, 133) - 66;
          val = sv;
        end
        2: val = $urandom;
        3: val = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        4: begin
          sv  = $urandom_range(4096, 1 << 22);
          val = $urandom_range(0, 1) ? -sv : sv;
        end
        5: begin
          sv  = $urandom_range(66, 4096);
          val = $urandom_range(0, 1) ? -sv : sv;
        end
        default: val = lces_pkg::FACTOR_ONE;
      endcase
      write_reg(lces_pkg::CFG_SCALE, val);

      case ($urandom_range(0, 4))
        0: val = $urandom;
        1: val = lces_pkg::CFG_DATA_W'(lces_pkg::Q_ONE);
        2: val = '0;
        3: val = $urandom_range(1, 65535);
        default: val = $urandom_range(50000, 65536);
      endcase
      write_reg(lces_pkg::CFG_ALPHA, val);

      case ($urandom_range(0, 4))
        0: val = $urandom;
        1: val = '0;
        2: val = $urandom_range(0, 1 << 20);
        3: val = 32'hFFFF_FFFF;
        default: val = $urandom_range(0, 1 << 24);
      endcase
      write_reg(lces_pkg::CFG_THRESH, val);

      burst_q = ($urandom_range(0, 3) == 0);
      mode    = $urandom_range(0, 9);
      base    = lces_pkg::RAW_W'($urandom);
      case ($urandom_range(0, 3))
        0: noise = 0;
        1: noise = 1;
        2: noise = 3;
        default: noise = 50;
      endcase

      for (k = 0; k < PHASE_ITEMS; k++) begin
        op = ($urandom_range(0, 19) == 0) ? lces_pkg::OP_CLEAR : lces_pkg::OP_PROCESS;
        if (mode < 6) begin
          raw = base + lces_pkg::RAW_W'($urandom_range(0, 2 * noise))
                - lces_pkg::RAW_W'(noise);
        end else if (mode < 8) begin
          raw = lces_pkg::RAW_W'($urandom);
        end else begin
          case ($urandom_range(0, 5))
            0: raw = 24'h7FFFFF;
            1: raw = 24'h800000;
            2: raw = 24'h000000;
            3: raw = 24'hFFFFFF;
            4: raw = 24'h000001;
            default: raw = tare_q;
          endcase
        end
        send_item(op, raw, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (pending_readings.size() != 0) begin
      report_mismatch("readings never returned", pending_readings.size(), '0);
    end
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lces_pkg.sv
sv/lces_ctrl.sv
sv/lces_dp.sv
sv/load_cell_ema_stability_core.sv
dv/tb_top.sv
